### rtl/point_decimator_with_bounds_defines.svh
// ----------------------------------------------------------------------------
// point_decimator_with_bounds_defines.svh
// Assertion macros used by the checker of the decimator.
// ----------------------------------------------------------------------------
`ifndef POINT_DECIMATOR_WITH_BOUNDS_DEFINES_SVH
`define POINT_DECIMATOR_WITH_BOUNDS_DEFINES_SVH

// same-cycle implication, reset masks the check
`define PDB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset masks the check
`define PDB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/pdb_pkg.sv
// ----------------------------------------------------------------------------
// pdb_pkg
// Shared widths, codes and types of the point decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package pdb_pkg;

   // configuration registers
   localparam int REG_W     = 25;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POINT_COUNT = 1'b0,
      CSR_BUDGET      = 1'b1
   } pdb_csr_type;

   // pick accumulator width
   localparam int ACC_W = 50;

   // result kinds
   localparam logic KIND_POINT = 1'b0;
   localparam logic KIND_STATS = 1'b1;

   // axis codes
   localparam int         NUM_AXES = 3;
   localparam int         AXIS_W   = 2;
   localparam logic [1:0] AXIS_X   = 2'd0;
   localparam logic [1:0] AXIS_Y   = 2'd1;
   localparam logic [1:0] AXIS_Z   = 2'd2;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int Q_PTR_W     = 2;
   localparam int Q_CNT_W     = 3;

   typedef struct packed {
      logic full;
      logic empty;
   } pdb_qstat_type;

endpackage

`default_nettype wire

### rtl/pdb_if.sv
// ----------------------------------------------------------------------------
// pdb_req_if / pdb_rsp_if
// Valid/ready channels carrying point beats in and result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdb_req_if #(parameter int COORD_WIDTH = 32) ();
   logic                          valid;
   logic                          ready;
   logic                          has_point;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] point_z;
   logic                          end_of_cloud;

   modport source (output valid, has_point, point_x, point_y, point_z, end_of_cloud,
                   input  ready);
   modport sink   (input  valid, has_point, point_x, point_y, point_z, end_of_cloud,
                   output ready);
endinterface

interface pdb_rsp_if #(parameter int COORD_WIDTH = 32) ();
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic signed [COORD_WIDTH-1:0] out_x;
   logic signed [COORD_WIDTH-1:0] out_y;
   logic signed [COORD_WIDTH-1:0] out_z;
   logic [1:0]                    axis;
   logic signed [COORD_WIDTH-1:0] axis_min;
   logic signed [COORD_WIDTH-1:0] axis_max;
   logic signed [COORD_WIDTH-1:0] axis_center;
   logic                          last;

   modport source (output valid, kind, out_x, out_y, out_z, axis, axis_min, axis_max,
                          axis_center, last,
                   input  ready);
   modport sink   (input  valid, kind, out_x, out_y, out_z, axis, axis_min, axis_max,
                          axis_center, last,
                   output ready);
endinterface

`default_nettype wire

### rtl/point_decimator_with_bounds.sv
// ----------------------------------------------------------------------------
// point_decimator_with_bounds
// Uniform-stride point cloud decimator with per-axis bounding box.
// ----------------------------------------------------------------------------
//
//   channel   | ports             | direction | beat
//   ----------+-------------------+-----------+------------------------------
//   request   | req_bus (sink)    | in        | one point and/or end marker
//   response  | rsp_bus (source)  | out       | kept point or axis statistics
//   registers | csr_we/index/wdata| in        | point_count, budget writes
//
// A request beat is taken every cycle while the 4-entry work queue has room;
// keep test and bound update finish in the accept cycle.
// The response side puts out one beat per cycle, while work is queued and
// rsp_bus.ready allows, through its output register: a kept point gives one
// beat, an end marker three, a point with end marker four. A result goes
// through the queue and then the output register. Reset is synchronous;
// no clearing pass follows. A stalled response fills the queue, then
// req_bus.ready drops.
`default_nettype none

module point_decimator_with_bounds #(
   parameter int COORD_WIDTH     = 32,
   parameter int MAX_POINTS_LOG2 = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [pdb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pdb_pkg::REG_W-1:0]     csr_wdata,
   pdb_req_if.sink                       req_bus,
   pdb_rsp_if.source                     rsp_bus
);

   // queue entry: keep flag, stats flag, point, per-axis min and max
   localparam int ENTRY_W = 2 + 9 * COORD_WIDTH;

   logic                   push, pop;
   logic [ENTRY_W-1:0]     push_data, head_data;
   pdb_pkg::pdb_qstat_type q_stat;

   // front: registers, keep decision, running bounds
   pdb_front #(
      .COORD_WIDTH     (COORD_WIDTH),
      .MAX_POINTS_LOG2 (MAX_POINTS_LOG2)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_bus),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   // decouples accept from emission so each side stalls on its own
   pdb_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .q_stat    (q_stat)
   );

   // back: expands each entry into its result beats
   pdb_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head_data (head_data),
      .pop       (pop),
      .rsp       (rsp_bus)
   );

endmodule

`default_nettype wire

### rtl/pdb_queue.sv
// ----------------------------------------------------------------------------
// pdb_queue
// Small register FIFO between the classify front and the emit back.
// ----------------------------------------------------------------------------
`default_nettype none

module pdb_queue #(
   parameter int WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      head_data,
   output pdb_pkg::pdb_qstat_type q_stat
);

   logic [WIDTH-1:0]              mem_ff [pdb_pkg::QUEUE_DEPTH];
   logic [pdb_pkg::Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [pdb_pkg::Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [pdb_pkg::Q_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + pdb_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + pdb_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + pdb_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - pdb_pkg::Q_CNT_W'(1);
      end
   end

   assign head_data    = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == pdb_pkg::Q_CNT_W'(pdb_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/pdb_front.sv
// ----------------------------------------------------------------------------
// pdb_front
// Takes point beats, decides keep/drop, tracks per-axis bounds, queues work.
// ----------------------------------------------------------------------------
`default_nettype none

module pdb_front #(
   parameter int COORD_WIDTH     = 32,
   parameter int MAX_POINTS_LOG2 = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [pdb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pdb_pkg::REG_W-1:0]          csr_wdata,
   pdb_req_if.sink                            req,
   input  pdb_pkg::pdb_qstat_type             q_stat,
   output logic                               push,
   output logic [2+9*COORD_WIDTH-1:0]         push_data
);

   localparam int CNT_W = MAX_POINTS_LOG2 + 1;
   localparam int CMP_W = (CNT_W > pdb_pkg::REG_W) ? CNT_W : pdb_pkg::REG_W;
   localparam int ACC_W = pdb_pkg::ACC_W;
   localparam int REG_W = pdb_pkg::REG_W;
   localparam int NA    = pdb_pkg::NUM_AXES;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic                            has_pt;
      logic                            has_stats;
      logic [COORD_WIDTH-1:0]          pt_x;
      logic [COORD_WIDTH-1:0]          pt_y;
      logic [COORD_WIDTH-1:0]          pt_z;
      logic [NA-1:0][COORD_WIDTH-1:0]  mins;
      logic [NA-1:0][COORD_WIDTH-1:0]  maxs;
   } entry_type;

   logic [REG_W-1:0]              point_count_ff, point_count_in;
   logic [REG_W-1:0]              budget_ff, budget_in;
   logic [CNT_W-1:0]              idx_ff, idx_in;
   logic [CNT_W-1:0]              kept_ff, kept_in;
   logic [ACC_W-1:0]              npn_ff, npn_in;
   logic [ACC_W-1:0]              itd_ff, itd_in;
   logic signed [COORD_WIDTH-1:0] min_ff [NA];
   logic signed [COORD_WIDTH-1:0] min_in [NA];
   logic signed [COORD_WIDTH-1:0] max_ff [NA];
   logic signed [COORD_WIDTH-1:0] max_in [NA];
   logic signed [COORD_WIDTH-1:0] min_new [NA];
   logic signed [COORD_WIDTH-1:0] max_new [NA];
   logic signed [COORD_WIDTH-1:0] pt [NA];

   logic             accept;
   logic             keep_all, single, decimating, keep_pt, keep;
   logic             idx_zero, idx_sat, kept_zero, kept_sat, below_budget;
   logic [REG_W-1:0] b_m1, cnt_m1;
   logic [ACC_W-1:0] den, step, npn_cur, itd_cur;
   logic [ACC_W:0]   reach;
   entry_type        entry;

   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;

   assign pt[0] = req.point_x;
   assign pt[1] = req.point_y;
   assign pt[2] = req.point_z;

   // keep decision
   always_comb begin
      b_m1         = budget_ff - REG_W'(1);
      cnt_m1       = point_count_ff - REG_W'(1);
      keep_all     = (budget_ff == '0) || (point_count_ff <= budget_ff);
      single       = (budget_ff == REG_W'(1));
      decimating   = !keep_all && !single;
      idx_zero     = (idx_ff == '0);
      idx_sat      = (idx_ff == CNT_MAX);
      kept_zero    = (kept_ff == '0);
      kept_sat     = (kept_ff == CNT_MAX);
      below_budget = (CMP_W'(kept_ff) < CMP_W'(budget_ff));
      den          = ACC_W'({b_m1, 1'b0});
      step         = ACC_W'({cnt_m1, 1'b0});
      // accumulator restarts on the first point of a cloud
      npn_cur      = idx_zero ? ACC_W'(b_m1) : npn_ff;
      itd_cur      = idx_zero ? '0 : itd_ff;
      reach        = {1'b0, itd_cur} + {1'b0, den};
      priority if (keep_all) begin
         keep_pt = 1'b1;
      end else if (single) begin
         keep_pt = idx_zero && kept_zero;
      end else begin
         keep_pt = below_budget && ({1'b0, npn_cur} < reach);
      end
      keep = req.has_point && keep_pt;
   end

   // bounds including the current point
   always_comb begin
      for (int a = 0; a < NA; a++) begin
         min_new[a] = min_ff[a];
         max_new[a] = max_ff[a];
         if (keep) begin
            if (kept_zero || (pt[a] < min_ff[a])) min_new[a] = pt[a];
            if (kept_zero || (pt[a] > max_ff[a])) max_new[a] = pt[a];
         end
      end
   end

   // next state
   always_comb begin
      point_count_in = point_count_ff;
      budget_in      = budget_ff;
      idx_in         = idx_ff;
      kept_in        = kept_ff;
      npn_in         = npn_ff;
      itd_in         = itd_ff;
      for (int a = 0; a < NA; a++) begin
         min_in[a] = min_ff[a];
         max_in[a] = max_ff[a];
      end

      if (csr_we) begin
         unique case (pdb_pkg::pdb_csr_type'(csr_index))
            pdb_pkg::CSR_POINT_COUNT: point_count_in = csr_wdata;
            pdb_pkg::CSR_BUDGET:      budget_in      = csr_wdata;
            default:                  point_count_in = point_count_ff;
         endcase
      end

      if (accept) begin
         if (req.has_point) begin
            if (decimating) begin
               npn_in = keep ? npn_cur + step : npn_cur;
               itd_in = idx_sat ? itd_cur : reach[ACC_W-1:0];
            end
            if (keep) begin
               kept_in = kept_sat ? kept_ff : kept_ff + CNT_W'(1);
               for (int a = 0; a < NA; a++) begin
                  min_in[a] = min_new[a];
                  max_in[a] = max_new[a];
               end
            end
            idx_in = idx_sat ? idx_ff : idx_ff + CNT_W'(1);
         end
         if (req.end_of_cloud) begin
            idx_in  = '0;
            kept_in = '0;
            itd_in  = '0;
            npn_in  = (budget_ff != '0) ? ACC_W'(b_m1) : '0;
            for (int a = 0; a < NA; a++) begin
               min_in[a] = '0;
               max_in[a] = '0;
            end
         end
      end
   end

   always_comb begin
      entry.has_pt    = keep;
      entry.has_stats = req.end_of_cloud;
      entry.pt_x      = req.point_x;
      entry.pt_y      = req.point_y;
      entry.pt_z      = req.point_z;
      for (int a = 0; a < NA; a++) begin
         entry.mins[a] = min_new[a];
         entry.maxs[a] = max_new[a];
      end
   end

   assign push      = accept && (keep || req.end_of_cloud);
   assign push_data = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         budget_ff      <= '0;
         idx_ff         <= '0;
         kept_ff        <= '0;
         npn_ff         <= '0;
         itd_ff         <= '0;
         for (int a = 0; a < NA; a++) begin
            min_ff[a] <= '0;
            max_ff[a] <= '0;
         end
      end else begin
         point_count_ff <= point_count_in;
         budget_ff      <= budget_in;
         idx_ff         <= idx_in;
         kept_ff        <= kept_in;
         npn_ff         <= npn_in;
         itd_ff         <= itd_in;
         for (int a = 0; a < NA; a++) begin
            min_ff[a] <= min_in[a];
            max_ff[a] <= max_in[a];
         end
      end
   end

endmodule

`default_nettype wire

### rtl/pdb_back.sv
// ----------------------------------------------------------------------------
// pdb_back
// Drains queued work into result beats: point, then x/y/z statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module pdb_back #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pdb_pkg::pdb_qstat_type      q_stat,
   input  logic [2+9*COORD_WIDTH-1:0]  head_data,
   output logic                        pop,
   pdb_rsp_if.source                   rsp
);

   localparam int NA     = pdb_pkg::NUM_AXES;
   localparam int AXIS_W = pdb_pkg::AXIS_W;

   typedef struct packed {
      logic                            has_pt;
      logic                            has_stats;
      logic [COORD_WIDTH-1:0]          pt_x;
      logic [COORD_WIDTH-1:0]          pt_y;
      logic [COORD_WIDTH-1:0]          pt_z;
      logic [NA-1:0][COORD_WIDTH-1:0]  mins;
      logic [NA-1:0][COORD_WIDTH-1:0]  maxs;
   } entry_type;

   typedef struct packed {
      logic                   kind;
      logic [COORD_WIDTH-1:0] out_x;
      logic [COORD_WIDTH-1:0] out_y;
      logic [COORD_WIDTH-1:0] out_z;
      logic [AXIS_W-1:0]      axis;
      logic [COORD_WIDTH-1:0] axis_min;
      logic [COORD_WIDTH-1:0] axis_max;
      logic [COORD_WIDTH-1:0] axis_center;
      logic                   last;
   } beat_type;

   entry_type              head;
   beat_type               beat_ff, beat_in;
   logic                   valid_ff, valid_in;
   logic                   pt_done_ff, pt_done_in;
   logic [AXIS_W-1:0]      axis_ff, axis_in;
   logic                   load, emit, emit_pt;
   logic [COORD_WIDTH-1:0] sel_min, sel_max;
   logic [COORD_WIDTH:0]   mid_sum;

   assign head = entry_type'(head_data);

   always_comb begin
      unique case (axis_ff)
         pdb_pkg::AXIS_X: begin
            sel_min = head.mins[0];
            sel_max = head.maxs[0];
         end
         pdb_pkg::AXIS_Y: begin
            sel_min = head.mins[1];
            sel_max = head.maxs[1];
         end
         pdb_pkg::AXIS_Z: begin
            sel_min = head.mins[2];
            sel_max = head.maxs[2];
         end
         default: begin
            sel_min = '0;
            sel_max = '0;
         end
      endcase
      // floor of the mean: sign-extended sum, drop the low bit
      mid_sum = {sel_min[COORD_WIDTH-1], sel_min} + {sel_max[COORD_WIDTH-1], sel_max};
   end

   always_comb begin
      load    = !valid_ff || rsp.ready;
      emit    = !q_stat.empty && load;
      emit_pt = head.has_pt && !pt_done_ff;
      pop     = emit && (emit_pt ? !head.has_stats : (axis_ff == pdb_pkg::AXIS_Z));

      valid_in   = emit || (valid_ff && !rsp.ready);
      pt_done_in = pt_done_ff;
      axis_in    = axis_ff;
      if (pop) begin
         pt_done_in = 1'b0;
         axis_in    = pdb_pkg::AXIS_X;
      end else if (emit && emit_pt) begin
         pt_done_in = 1'b1;
      end else if (emit) begin
         axis_in = axis_ff + AXIS_W'(1);
      end

      beat_in = beat_ff;
      if (emit) begin
         if (emit_pt) begin
            beat_in.kind        = pdb_pkg::KIND_POINT;
            beat_in.out_x       = head.pt_x;
            beat_in.out_y       = head.pt_y;
            beat_in.out_z       = head.pt_z;
            beat_in.axis        = pdb_pkg::AXIS_X;
            beat_in.axis_min    = '0;
            beat_in.axis_max    = '0;
            beat_in.axis_center = '0;
            beat_in.last        = 1'b0;
         end else begin
            beat_in.kind        = pdb_pkg::KIND_STATS;
            beat_in.out_x       = '0;
            beat_in.out_y       = '0;
            beat_in.out_z       = '0;
            beat_in.axis        = axis_ff;
            beat_in.axis_min    = sel_min;
            beat_in.axis_max    = sel_max;
            beat_in.axis_center = mid_sum[COORD_WIDTH:1];
            beat_in.last        = (axis_ff == pdb_pkg::AXIS_Z);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         pt_done_ff <= 1'b0;
         axis_ff    <= pdb_pkg::AXIS_X;
      end else begin
         valid_ff   <= valid_in;
         pt_done_ff <= pt_done_in;
         axis_ff    <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.kind        = beat_ff.kind;
   assign rsp.out_x       = beat_ff.out_x;
   assign rsp.out_y       = beat_ff.out_y;
   assign rsp.out_z       = beat_ff.out_z;
   assign rsp.axis        = beat_ff.axis;
   assign rsp.axis_min    = beat_ff.axis_min;
   assign rsp.axis_max    = beat_ff.axis_max;
   assign rsp.axis_center = beat_ff.axis_center;
   assign rsp.last        = beat_ff.last;

endmodule

`default_nettype wire

### rtl/pdb_checker.sv
// ----------------------------------------------------------------------------
// pdb_checker
// Port-level checks on the result channel of the decimator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_decimator_with_bounds_defines.svh"

module pdb_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_kind,
   input logic signed [COORD_WIDTH-1:0] rsp_out_x,
   input logic signed [COORD_WIDTH-1:0] rsp_out_y,
   input logic signed [COORD_WIDTH-1:0] rsp_out_z,
   input logic [1:0]                    rsp_axis,
   input logic signed [COORD_WIDTH-1:0] rsp_axis_min,
   input logic signed [COORD_WIDTH-1:0] rsp_axis_max,
   input logic signed [COORD_WIDTH-1:0] rsp_axis_center,
   input logic                          rsp_last
);

   `PDB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_axis) && $stable(rsp_out_x) && $stable(rsp_axis_center), "stalled response beat changed")
   `PDB_ASSERT_NOW(a_last_is_z, clock, reset, rsp_valid && rsp_last, rsp_kind == pdb_pkg::KIND_STATS && rsp_axis == pdb_pkg::AXIS_Z, "last flag off the z statistics beat")
   `PDB_ASSERT_NOW(a_point_clean, clock, reset, rsp_valid && rsp_kind == pdb_pkg::KIND_POINT, rsp_axis == pdb_pkg::AXIS_X && rsp_axis_min == 0 && rsp_axis_max == 0 && rsp_axis_center == 0 && !rsp_last, "point beat carries statistics")
   `PDB_ASSERT_NOW(a_stats_order, clock, reset, rsp_valid && rsp_kind == pdb_pkg::KIND_STATS, rsp_out_x == 0 && rsp_out_y == 0 && rsp_out_z == 0 && rsp_axis_min <= rsp_axis_center && rsp_axis_center <= rsp_axis_max, "statistics beat out of bounds")

endmodule

bind point_decimator_with_bounds pdb_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_pdb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_kind        (rsp_bus.kind),
   .rsp_out_x       (rsp_bus.out_x),
   .rsp_out_y       (rsp_bus.out_y),
   .rsp_out_z       (rsp_bus.out_z),
   .rsp_axis        (rsp_bus.axis),
   .rsp_axis_min    (rsp_bus.axis_min),
   .rsp_axis_max    (rsp_bus.axis_max),
   .rsp_axis_center (rsp_bus.axis_center),
   .rsp_last        (rsp_bus.last)
);

`default_nettype wire

### sim/point_decimator_with_bounds_tb.sv
// ----------------------------------------------------------------------------
// point_decimator_with_bounds_tb
// Self-checking bench for the stride decimator with per-axis bounds.
// A model in the bench predicts the kept points and the
// min/max/center statistics of every cloud. Directed clouds cover keep-all,
// budget of one, empty clouds, merged point/end beats, overrun and register
// changes mid-cloud. Random clouds follow, with random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module point_decimator_with_bounds_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          COORD_W   = 32;
   localparam int          CYCLE_CAP = 200_000;   // far above the slowest legal run
   localparam int          LAT_PAD   = 10;        // above queue depth plus output register
   localparam logic [24:0] CNT_SAT   = '1;        // index/kept counters stop here
   localparam logic [24:0] REG_TOP   = 25'd16777216;

   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;

   localparam logic [pdb_pkg::AXIS_W-1:0] AXIS_CODE [pdb_pkg::NUM_AXES] =
      '{pdb_pkg::AXIS_X, pdb_pkg::AXIS_Y, pdb_pkg::AXIS_Z};

   // one response beat as the bench expects it
   typedef struct {
      logic                       kind;
      logic [COORD_W-1:0]         px, py, pz;
      logic [pdb_pkg::AXIS_W-1:0] axis;
      logic [COORD_W-1:0]         lo, hi, mid;
      logic                       last;
   } bound_result_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   pdb_pkg::pdb_csr_type      csr_index;
   logic [pdb_pkg::REG_W-1:0] csr_wdata;

   pdb_req_if #(.COORD_WIDTH(COORD_W)) req_bus ();
   pdb_rsp_if #(.COORD_WIDTH(COORD_W)) rsp_bus ();

   point_decimator_with_bounds #(
      .COORD_WIDTH    (COORD_W),
      .MAX_POINTS_LOG2(24)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus)
   );

   // ------------------------------------------------------------------------
   // Mirror of the block: registers, pick accumulator and running bounds
   // ------------------------------------------------------------------------
   logic [24:0]               cfg_count;
   logic [24:0]               cfg_budget;
   logic [24:0]               pts_seen;      // input index within the cloud
   logic [49:0]               pick_target;   // next pick, scaled by 2*(b-1)
   logic [49:0]               pick_pos;      // index scaled by 2*(b-1)
   logic [24:0]               kept_pts;
   logic signed [COORD_W-1:0] lo_bound [pdb_pkg::NUM_AXES];
   logic signed [COORD_W-1:0] hi_bound [pdb_pkg::NUM_AXES];

   bound_result_type awaited_outputs [$];

   int  fault_count = 0;
   int  beats_sent  = 0;   // beats carrying a point or an end marker
   bit  idling      = 1'b0;

   // per-cloud state back to its cleared values
   function automatic void clear_cloud_state();
      pts_seen    = '0;
      pick_target = (cfg_budget != 0) ? {25'd0, cfg_budget - 25'd1} : '0;
      pick_pos    = '0;
      kept_pts    = '0;
      for (int a = 0; a < pdb_pkg::NUM_AXES; a++) begin
         lo_bound[a] = '0;
         hi_bound[a] = '0;
      end
   endfunction

   // Advance the mirror by one accepted request beat and queue what the
   // block must put out for it: at most one kept point, then three stats if it ends the cloud.
   function automatic void decimate_and_bound(input logic hp,
                                              input logic signed [COORD_W-1:0] x, y, z,
                                              input logic eoc);
      logic signed [COORD_W-1:0] pt [pdb_pkg::NUM_AXES];
      logic                      keep;
      logic [49:0]               stride;
      logic [50:0]               reach;
      logic signed [COORD_W:0]   sum;
      bound_result_type          r;

      pt[0] = x;
      pt[1] = y;
      pt[2] = z;
      if (hp) begin
         keep = 1'b0;
         if (cfg_budget == 0 || cfg_count <= cfg_budget) begin
            keep = 1'b1;                                  // keep-all mode
         end else if (cfg_budget == 1) begin
            keep = (pts_seen == 0) && (kept_pts == 0);    // only index 0
         end else begin
            stride = {24'd0, cfg_budget - 25'd1, 1'b0};
            // the accumulator is reloaded at the first point of each cloud
            if (pts_seen == 0) begin
               pick_target = {25'd0, cfg_budget - 25'd1};
               pick_pos    = '0;
            end
            reach = {1'b0, pick_pos} + {1'b0, stride};
            keep  = (kept_pts < cfg_budget) && ({1'b0, pick_target} < reach);
            if (keep) pick_target = pick_target + {24'd0, cfg_count - 25'd1, 1'b0};
            if (pts_seen != CNT_SAT) pick_pos = pick_pos + stride;
         end

         if (keep) begin
            for (int a = 0; a < pdb_pkg::NUM_AXES; a++) begin
               if (kept_pts == 0) begin
                  lo_bound[a] = pt[a];
                  hi_bound[a] = pt[a];
               end else begin
                  if (pt[a] < lo_bound[a]) lo_bound[a] = pt[a];
                  if (pt[a] > hi_bound[a]) hi_bound[a] = pt[a];
               end
            end
            if (kept_pts != CNT_SAT) kept_pts = kept_pts + 25'd1;
            r.kind = pdb_pkg::KIND_POINT;
            r.px   = x;
            r.py   = y;
            r.pz   = z;
            r.axis = pdb_pkg::AXIS_X;
            r.lo   = '0;
            r.hi   = '0;
            r.mid  = '0;
            r.last = 1'b0;
            awaited_outputs.insert(awaited_outputs.size(), r);
         end
         if (pts_seen != CNT_SAT) pts_seen = pts_seen + 25'd1;
      end

      if (eoc) begin
         for (int a = 0; a < pdb_pkg::NUM_AXES; a++) begin
            // floor of the midpoint, no overflow in the wider sum
            sum    = lo_bound[a] + hi_bound[a];
            r.kind = pdb_pkg::KIND_STATS;
            r.px   = '0;
            r.py   = '0;
            r.pz   = '0;
            r.axis = AXIS_CODE[a];
            r.lo   = lo_bound[a];
            r.hi   = hi_bound[a];
            r.mid  = sum[COORD_W:1];
            r.last = (AXIS_CODE[a] == pdb_pkg::AXIS_Z);
            awaited_outputs.insert(awaited_outputs.size(), r);
         end
         clear_cloud_state();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Clock, run limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_CAP) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: random back-pressure bursts, checking on each beat
   // ------------------------------------------------------------------------
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (idling && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   function automatic void check_field(input string name,
                                       input logic [COORD_W-1:0] want, got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fault_count++;
      end
   endfunction

   // compare one accepted response beat with the oldest expectation
   task automatic check_beat();
      bound_result_type want;
      if (awaited_outputs.size() == 0) begin
         $error("response beat with nothing expected (kind %b)", rsp_bus.kind);
         fault_count++;
      end else begin
         want = awaited_outputs.pop_front();
         check_field("kind",        want.kind, rsp_bus.kind);
         check_field("out_x",       want.px,   rsp_bus.out_x);
         check_field("out_y",       want.py,   rsp_bus.out_y);
         check_field("out_z",       want.pz,   rsp_bus.out_z);
         check_field("axis",        want.axis, rsp_bus.axis);
         check_field("axis_min",    want.lo,   rsp_bus.axis_min);
         check_field("axis_max",    want.hi,   rsp_bus.axis_max);
         check_field("axis_center", want.mid,  rsp_bus.axis_center);
         check_field("last",        want.last, rsp_bus.last);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_beat();
   end

   // ------------------------------------------------------------------------
   // Request side helpers
   // ------------------------------------------------------------------------

   // Present one beat and hold it until taken; the caller's next beat or a
   // drain lowers valid, so valid stays up across back-to-back beats.
   task automatic send_beat(input logic hp,
                            input logic signed [COORD_W-1:0] x, y, z,
                            input logic eoc);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.has_point    <= hp;
      req_bus.point_x      <= x;
      req_bus.point_y      <= y;
      req_bus.point_z      <= z;
      req_bus.end_of_cloud <= eoc;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      decimate_and_bound(hp, x, y, z, eoc);
      if (hp || eoc) beats_sent++;
   endtask

   // Stop sending and let every expected beat come out. Beats that yield no
   // result may still be in flight, so a padding wait follows.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (awaited_outputs.size() != 0) @(posedge clock);
      repeat (LAT_PAD) @(posedge clock);
   endtask

   // both registers, one write per cycle; only called while idle
   task automatic load_registers(input logic [24:0] count, input logic [24:0] bud);
      csr_we    <= 1'b1;
      csr_index <= pdb_pkg::CSR_POINT_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      cfg_count  = count;
      csr_index <= pdb_pkg::CSR_BUDGET;
      csr_wdata <= bud;
      @(posedge clock);
      cfg_budget = bud;
      csr_we    <= 1'b0;
   endtask

   // extremes often, otherwise any 32-bit value
   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------------

   // keep-all with count and budget both zero; coordinate extremes, a beat
   // with neither point nor end, and the end marker riding on a point
   task automatic test_keep_all_extremes();
      load_registers('0, '0);
      send_beat(1'b1, COORD_MIN, COORD_MAX, '0, 1'b0);
      send_beat(1'b1, COORD_MAX, COORD_MIN, '1, 1'b0);
      send_beat(1'b0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      send_beat(1'b1, '0, '1, COORD_MIN, 1'b1);
      drain_results();
   endtask

   // end markers with no kept point give all-zero stats
   task automatic test_empty_cloud();
      send_beat(1'b0, COORD_MAX, COORD_MIN, '1, 1'b1);
      send_beat(1'b0, '1, '1, '1, 1'b0);
      send_beat(1'b0, pick_coord(), pick_coord(), pick_coord(), 1'b1);
      drain_results();
   endtask

   // budget of one keeps the first point only
   task automatic test_budget_one();
      load_registers(25'd5, 25'd1);
      send_beat(1'b1, 32'sd65536, -32'sd65536, 32'sd3, 1'b0);
      send_beat(1'b1, COORD_MIN, COORD_MAX, '0, 1'b0);
      send_beat(1'b1, pick_coord(), pick_coord(), pick_coord(), 1'b1);
      drain_results();
   endtask

   // more points than announced, in keep-all and in decimation mode
   task automatic test_overrun();
      load_registers(25'd2, 25'd3);
      repeat (3) send_beat(1'b1, pick_coord(), pick_coord(), pick_coord(), 1'b0);
      send_beat(1'b0, '0, '0, '0, 1'b1);
      drain_results();
      // count 4, budget 2: picks at index 0 and 3, nothing past that
      load_registers(25'd4, 25'd2);
      for (int i = 0; i < 5; i++)
         send_beat(1'b1, pick_coord(), pick_coord(), pick_coord(), i == 4);
      drain_results();
   endtask

   // start in keep-all, switch to decimation halfway through the cloud
   task automatic test_register_change_mid_cloud();
      load_registers(25'd6, 25'd0);
      repeat (2) send_beat(1'b1, pick_coord(), pick_coord(), pick_coord(), 1'b0);
      drain_results();
      load_registers(25'd6, 25'd3);
      send_beat(1'b1, pick_coord(), pick_coord(), pick_coord(), 1'b0);
      send_beat(1'b1, pick_coord(), pick_coord(), pick_coord(), 1'b1);
      drain_results();
   endtask

   // register values of 2**24: wide stride in decimation, then keep-all
   task automatic test_register_extremes();
      load_registers(REG_TOP, REG_TOP - 25'd1);
      send_beat(1'b1, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      send_beat(1'b1, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
      drain_results();
      load_registers(REG_TOP, REG_TOP);
      send_beat(1'b1, pick_coord(), pick_coord(), pick_coord(), 1'b1);
      drain_results();
   endtask

   // ------------------------------------------------------------------------
   // Random clouds: mostly well-formed, some short, long, unterminated or
   // with stray empty beats; register settings change between clouds.
   // ------------------------------------------------------------------------
   task automatic test_random_clouds();
      int unsigned count, bud, npts;
      int          stop_at;
      bit          closes, end_on_point;

      stop_at = beats_sent + 230;
      while (beats_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0: begin
               count = $urandom_range(1, 24);
               bud   = 0;
            end
            1: begin
               count = $urandom_range(2, 20);
               bud   = 1;
            end
            2: begin
               count = $urandom_range(0, 20);
               bud   = count + $urandom_range(0, 3);
            end
            3: begin
               count = 16777216 - $urandom_range(0, 1000);
               bud   = $urandom_range(2, 8);
            end
            4: begin
               count = $urandom_range(0, 16777216);
               bud   = $urandom_range(0, 16777216);
            end
            default: begin
               count = $urandom_range(3, 30);
               bud   = $urandom_range(2, count - 1);
            end
         endcase

         npts = (count <= 30) ? count : $urandom_range(1, 12);
         if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 0) npts = npts + $urandom_range(1, 3);
            else if (npts != 0) npts = npts - 1;
         end
         closes       = ($urandom_range(0, 9) != 0);
         end_on_point = (npts != 0) && ($urandom_range(0, 1) == 1);

         drain_results();
         idling = (beats_sent < stop_at - 60) && ($urandom_range(0, 3) != 0);
         load_registers(count[24:0], bud[24:0]);

         for (int i = 0; i < npts; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_beat(1'b0, pick_coord(), pick_coord(), pick_coord(), 1'b0);
            send_beat(1'b1, pick_coord(), pick_coord(), pick_coord(),
                      closes && end_on_point && (i == npts - 1));
         end
         if (closes && !end_on_point)
            send_beat(1'b0, pick_coord(), pick_coord(), pick_coord(), 1'b1);
      end
      idling = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= pdb_pkg::CSR_POINT_COUNT;
      csr_wdata            <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.has_point    <= 1'b0;
      req_bus.point_x      <= '0;
      req_bus.point_y      <= '0;
      req_bus.point_z      <= '0;
      req_bus.end_of_cloud <= 1'b0;
      cfg_count  = '0;
      cfg_budget = '0;
      clear_cloud_state();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      idling = 1'b1;
      test_keep_all_extremes();
      test_empty_cloud();
      test_budget_one();
      test_overrun();
      test_register_change_mid_cloud();
      test_register_extremes();
      test_random_clouds();
      drain_results();

      if (fault_count == 0 && awaited_outputs.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
